@@ sv/btas_pkg.sv @@
// shared types, constants and helpers of the block transfer address sequencer
package btas_pkg;

  localparam int unsigned NumRegs   = 16;
  localparam int unsigned IdxW      = $clog2(NumRegs);
  localparam int unsigned CntW      = $clog2(NumRegs) + 1;
  localparam int unsigned AddrW     = 32;
  localparam int unsigned WordBytes = 4;
  localparam logic [IdxW-1:0] PcReg = IdxW'(NumRegs - 1);
  localparam logic [NumRegs-1:0] PcOnlyList = NumRegs'(1) << PcReg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_EMIT
  } seq_state_e;

  // control from the sequencer to the shared address adder
  typedef struct packed {
    logic             load_base;
    logic [AddrW-1:0] base;
    logic             calc_final;
    logic             up;
    logic [CntW-1:0]  count;
    logic             step;
  } addr_ctl_t;

  function automatic logic [CntW-1:0] pop_count(input logic [NumRegs-1:0] list);
    logic [CntW-1:0] cnt;
    cnt = '0;
    for (int i = 0; i < NumRegs; i++) begin
      cnt = cnt + CntW'(list[i]);
    end
    return cnt;
  endfunction

  function automatic logic [IdxW-1:0] lowest_set(input logic [NumRegs-1:0] list);
    logic [IdxW-1:0] idx;
    idx = '0;
    for (int i = NumRegs - 1; i >= 0; i--) begin
      if (list[i]) begin
        idx = IdxW'(i);
      end
    end
    return idx;
  endfunction

endpackage

@@ sv/btas_if.sv @@
// request and response channel interfaces

interface btas_req_if;
  import btas_pkg::*;
  logic               valid;
  logic               ready;
  logic [NumRegs-1:0] register_list;
  logic [IdxW-1:0]    base_register;
  logic [AddrW-1:0]   base_value;
  logic               is_load;
  logic               pre_index;
  logic               step_up;
  logic               s_bit;
  logic               write_back;

  modport source (
    output valid, register_list, base_register, base_value, is_load, pre_index,
           step_up, s_bit, write_back,
    input  ready
  );
  modport sink (
    input  valid, register_list, base_register, base_value, is_load, pre_index,
           step_up, s_bit, write_back,
    output ready
  );
endinterface

interface btas_rsp_if;
  import btas_pkg::*;
  logic             valid;
  logic             ready;
  logic [IdxW-1:0]  reg_index;
  logic [AddrW-1:0] address;
  logic             load_access;
  logic             user_bank;
  logic             store_plus_four;
  logic             base_update;
  logic [AddrW-1:0] final_base;
  logic             restore_status;
  logic             reload_pipeline;
  logic             last;

  modport source (
    output valid, reg_index, address, load_access, user_bank, store_plus_four,
           base_update, final_base, restore_status, reload_pipeline, last,
    input  ready
  );
  modport sink (
    input  valid, reg_index, address, load_access, user_bank, store_plus_four,
           base_update, final_base, restore_status, reload_pipeline, last,
    output ready
  );
endinterface

@@ sv/btas_addr.sv @@
// address unit: one shared add/subtract for the final base and every address step
module btas_addr
  import btas_pkg::*;
(
  input  logic             clk_i,
  input  addr_ctl_t        ctl_i,
  output logic [AddrW-1:0] addr_o,
  output logic [AddrW-1:0] addr_next_o,
  output logic [AddrW-1:0] final_o
);

  logic [AddrW-1:0] addr_q, addr_d;
  logic [AddrW-1:0] final_q, final_d;
  logic [AddrW-1:0] op_b;
  logic             sub;
  logic [AddrW-1:0] sum;

  always_comb begin
    if (ctl_i.calc_final) begin
      op_b = AddrW'({ctl_i.count, 2'b00});
      sub  = !ctl_i.up;
    end else begin
      op_b = AddrW'(WordBytes);
      sub  = 1'b0;
    end
    sum = addr_q + (sub ? ~op_b : op_b) + AddrW'(sub);
  end

  always_comb begin
    addr_d  = addr_q;
    final_d = final_q;
    if (ctl_i.load_base) begin
      addr_d = ctl_i.base;
    end else if (ctl_i.calc_final) begin
      final_d = sum;
      // descending transfers start from the lowest address
      if (!ctl_i.up) begin
        addr_d = sum;
      end
    end else if (ctl_i.step) begin
      addr_d = sum;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q  <= addr_d;
    final_q <= final_d;
  end

  assign addr_o      = addr_q;
  assign addr_next_o = sum;
  assign final_o     = final_q;

endmodule

@@ sv/btas_seq.sv @@
// sequencer: takes the instruction, walks the register list and registers each request
module btas_seq
  import btas_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  btas_req_if.sink         req,
  btas_rsp_if.source       rsp,
  output addr_ctl_t        addr_ctl_o,
  input  logic [AddrW-1:0] addr_i,
  input  logic [AddrW-1:0] addr_next_i,
  input  logic [AddrW-1:0] final_i
);

  seq_state_e state_q, state_d;

  logic [NumRegs-1:0] list_q, list_d;
  logic [CntW-1:0]    count_q, count_d;
  logic               load_q, pre_q, up_q, ubank_q, wb_q, s_q, pc_listed_q, first_q;

  logic               out_valid_q, out_valid_d;
  logic [IdxW-1:0]    out_idx_q;
  logic [AddrW-1:0]   out_addr_q;
  logic [AddrW-1:0]   out_final_q;
  logic               out_load_q, out_ubank_q, out_spf_q, out_bu_q;
  logic               out_rs_q, out_rp_q, out_last_q;

  logic               accept;
  logic               emit;
  logic [CntW-1:0]    in_count;
  logic [NumRegs-1:0] in_list;
  logic [IdxW-1:0]    cur_idx;
  logic [NumRegs-1:0] list_rest;
  logic               is_last;

  assign in_count  = pop_count(req.register_list);
  // empty list moves only the pc but steps the base as if all were listed
  assign in_list   = (in_count == '0) ? PcOnlyList : req.register_list;
  assign cur_idx   = lowest_set(list_q);
  assign list_rest = list_q & (list_q - NumRegs'(1));
  assign is_last   = (list_rest == '0);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (req.valid) state_d = ST_CALC;
      ST_CALC: state_d = ST_EMIT;
      ST_EMIT: if (emit && is_last) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs of the state machine
  always_comb begin
    req.ready  = 1'b0;
    emit       = 1'b0;
    addr_ctl_o = '0;
    addr_ctl_o.base  = req.base_value;
    addr_ctl_o.up    = up_q;
    addr_ctl_o.count = count_q;
    unique case (state_q)
      ST_IDLE: begin
        req.ready            = 1'b1;
        addr_ctl_o.load_base = req.valid;
      end
      ST_CALC: addr_ctl_o.calc_final = 1'b1;
      ST_EMIT: begin
        emit            = !out_valid_q || rsp.ready;
        addr_ctl_o.step = emit;
      end
      default: ;
    endcase
  end

  assign accept = req.valid && req.ready;

  always_comb begin
    list_d  = list_q;
    count_d = count_q;
    if (accept) begin
      list_d  = in_list;
      count_d = (in_count == '0) ? CntW'(NumRegs) : in_count;
    end else if (emit) begin
      list_d = list_rest;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (rsp.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    list_q  <= list_d;
    count_q <= count_d;
    if (accept) begin
      load_q      <= req.is_load;
      pre_q       <= req.pre_index ^ !req.step_up;
      up_q        <= req.step_up;
      s_q         <= req.s_bit;
      wb_q        <= req.write_back;
      pc_listed_q <= in_list[PcReg];
      ubank_q     <= req.s_bit && !(in_list[PcReg] && req.is_load);
      first_q     <= 1'b1;
    end else if (emit) begin
      first_q     <= 1'b0;
    end
    if (emit) begin
      out_idx_q   <= cur_idx;
      out_addr_q  <= pre_q ? addr_next_i : addr_i;
      out_final_q <= final_i;
      out_load_q  <= load_q;
      out_ubank_q <= ubank_q;
      out_spf_q   <= !load_q && (cur_idx == PcReg);
      out_bu_q    <= first_q && wb_q;
      out_rs_q    <= is_last && pc_listed_q && load_q && s_q;
      out_rp_q    <= is_last && pc_listed_q && load_q;
      out_last_q  <= is_last;
    end
  end

  assign rsp.valid           = out_valid_q;
  assign rsp.reg_index       = out_idx_q;
  assign rsp.address         = out_addr_q;
  assign rsp.load_access     = out_load_q;
  assign rsp.user_bank       = out_ubank_q;
  assign rsp.store_plus_four = out_spf_q;
  assign rsp.base_update     = out_bu_q;
  assign rsp.final_base      = out_final_q;
  assign rsp.restore_status  = out_rs_q;
  assign rsp.reload_pipeline = out_rp_q;
  assign rsp.last            = out_last_q;

endmodule

@@ sv/block_transfer_address_sequencer.sv @@
// block transfer address sequencer, top level
// an instruction with n listed registers (n = 1 for an empty list) is handled in these steps:
// accept in IDLE, the final base in the shared adder in CALC, then in EMIT one request a cycle
// while the held response is taken or none is held; each request leaves through an output register
// the shared adder forms the final base and then every address step, so requests leave serially
// reset clears the sequencer state and the response valid; no clearing pass is needed
module block_transfer_address_sequencer
  import btas_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  btas_req_if.sink   req_i,
  btas_rsp_if.source rsp_o
);

  addr_ctl_t        addr_ctl;
  logic [AddrW-1:0] addr;
  logic [AddrW-1:0] addr_next;
  logic [AddrW-1:0] final_base;

  btas_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req         (req_i),
    .rsp         (rsp_o),
    .addr_ctl_o  (addr_ctl),
    .addr_i      (addr),
    .addr_next_i (addr_next),
    .final_i     (final_base)
  );

  btas_addr u_addr (
    .clk_i       (clk_i),
    .ctl_i       (addr_ctl),
    .addr_o      (addr),
    .addr_next_o (addr_next),
    .final_o     (final_base)
  );

endmodule
